// ===== sv/sliding_window_delete_tracker_defines.svh =====
// Assertion macros shared by the checker of the sliding-window delete tracker.
`ifndef SLIDING_WINDOW_DELETE_TRACKER_DEFINES_SVH
`define SLIDING_WINDOW_DELETE_TRACKER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define SWDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define SWDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/swdt_pkg.sv =====
// Package of types, constants and register codes for the sliding-window delete tracker.
`default_nettype none

package swdt_pkg;

  localparam int MAX_WINDOW    = 4096;
  localparam int RING_AW       = $clog2(MAX_WINDOW);
  localparam int CNT_W         = 13;
  localparam int TOT_W         = 40;
  localparam int KEY_W         = 16;
  localparam int TYPE_W        = 3;
  localparam int PROD_W        = TOT_W + CNT_W;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 40;

  localparam logic [KEY_W-1:0]  MIN_KEY_BYTES = KEY_W'(4);
  localparam logic [CNT_W-1:0]  MAX_WINDOW_CNT = CNT_W'(MAX_WINDOW);

  localparam logic [TYPE_W-1:0] ET_DELETE        = 3'd1;
  localparam logic [TYPE_W-1:0] ET_SINGLE_DELETE = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELETE_THRESHOLD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_THRESHOLD   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SINGLE     = 4'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] entry_type;
    logic [KEY_W-1:0]  key_bytes;
    logic [TOT_W-1:0]  written_bytes;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] deletes_in_window;
    logic [CNT_W-1:0] max_deletes_seen;
    logic             need_compact;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] window;
    logic [CNT_W-1:0] delete_threshold;
    logic [TOT_W-1:0] size_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] window_count;
    logic [CNT_W-1:0] window_max;
    logic [TOT_W-1:0] entries_counted;
    logic [TOT_W-1:0] deletes_counted;
    logic [TOT_W-1:0] last_file_size;
  } snap_t;

endpackage

`default_nettype wire

// ===== sv/sliding_window_delete_tracker.sv =====
// Top level of the sliding-window delete tracker.
//
// Input entries arrive on in_valid/in_ready with in_data; each accepted transaction
// yields exactly one result on out_valid/out_ready with out_data, in order.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes are expected only while the block is idle.
// A new entry can be accepted in every cycle unless the result stages are full; the
// window state, ring bit and totals are updated at the accepting edge and the ring
// bit for the next position is prefetched from the delete-bit memory by a registered
// read. The result passes through three registers: the state snapshot is taken at
// the accepting edge, then the two ratio products are registered, then the decision
// in the output register. Sustained rate is one entry per cycle while the receiver
// takes every result. When the receiver stalls, the three result stages fill and
// in_ready falls only once all of them hold results. Reset clears all state and the
// registers to their defaults; the ring needs no clearing pass, as bits not yet
// written since the last window write are masked to zero until the ring wraps.
`default_nettype none

module sliding_window_delete_tracker
  import swdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  snap_t snap_next;
  logic  take;
  logic  free;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign take      = in_valid && free;

  swdt_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_data),
    .cfg       (cfg),
    .snap_next (snap_next)
  );

  swdt_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .snap_next (snap_next),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/swdt_ring.sv =====
// Ring memory of per-entry delete bits with a registered read and write bypass.
`default_nettype none

module swdt_ring
  import swdt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [RING_AW-1:0] wr_addr,
  input  wire logic               wr_bit,
  input  wire logic [RING_AW-1:0] rd_addr,
  output logic                    rd_bit
);

  logic mem [MAX_WINDOW];
  logic mem_q;
  logic byp;
  logic byp_bit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    byp     <= wr_en && (wr_addr == rd_addr);
    byp_bit <= wr_bit;
  end

  assign rd_bit = byp ? byp_bit : mem_q;

endmodule

`default_nettype wire

// ===== sv/swdt_track.sv =====
// Configuration registers and window, maximum and total tracking state.
`default_nettype none

module swdt_track
  import swdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  take,
  input  wire in_item_t              item,
  output cfg_t                       cfg,
  output snap_t                      snap_next
);

  logic [CNT_W-1:0]   window_len;
  logic [CNT_W-1:0]   delete_threshold;
  logic [TOT_W-1:0]   size_threshold;
  logic               count_single;
  logic [RING_AW-1:0] ring_position;
  logic               wrapped;
  logic [CNT_W-1:0]   window_count;
  logic [CNT_W-1:0]   window_max;
  logic [TOT_W-1:0]   entries_counted;
  logic [TOT_W-1:0]   deletes_counted;
  logic [TOT_W-1:0]   last_file_size;

  logic [CNT_W-1:0]   window_len_next;
  logic [CNT_W-1:0]   delete_threshold_next;
  logic [TOT_W-1:0]   size_threshold_next;
  logic               count_single_next;
  logic [RING_AW-1:0] ring_position_next;
  logic               wrapped_next;
  logic [CNT_W-1:0]   window_count_next;
  logic [CNT_W-1:0]   window_max_next;
  logic [TOT_W-1:0]   entries_counted_next;
  logic [TOT_W-1:0]   deletes_counted_next;
  logic [TOT_W-1:0]   last_file_size_next;

  logic [CNT_W-1:0]   eff_window;
  logic               is_del;
  logic               key_ok;
  logic               old_bit;
  logic               rd_bit;
  logic               wr_en;
  logic [CNT_W-1:0]   pos_inc;

  assign eff_window = (window_len > MAX_WINDOW_CNT) ? MAX_WINDOW_CNT : window_len;
  assign is_del = (item.entry_type == ET_DELETE) ||
                  ((item.entry_type == ET_SINGLE_DELETE) && count_single);
  assign key_ok  = item.key_bytes >= MIN_KEY_BYTES;
  assign old_bit = wrapped && rd_bit;
  assign pos_inc = CNT_W'(ring_position) + CNT_W'(1);

  always_comb begin
    window_len_next       = window_len;
    delete_threshold_next = delete_threshold;
    size_threshold_next   = size_threshold;
    count_single_next     = count_single;
    ring_position_next    = ring_position;
    wrapped_next          = wrapped;
    window_count_next     = window_count;
    window_max_next       = window_max;
    entries_counted_next  = entries_counted;
    deletes_counted_next  = deletes_counted;
    last_file_size_next   = last_file_size;
    wr_en                 = 1'b0;

    if (take && key_ok) begin
      if (eff_window != '0) begin
        wr_en = 1'b1;
        if (old_bit != is_del) begin
          if (!is_del) begin
            if (window_count != '0) begin
              window_count_next = window_count - CNT_W'(1);
            end
          end else begin
            window_count_next = window_count + CNT_W'(1);
            if (window_count_next > window_max) begin
              window_max_next = window_count_next;
            end
          end
        end
        if (pos_inc >= eff_window) begin
          ring_position_next = '0;
          wrapped_next       = 1'b1;
        end else begin
          ring_position_next = pos_inc[RING_AW-1:0];
        end
      end
      if (entries_counted != '1) begin
        entries_counted_next = entries_counted + TOT_W'(1);
      end
      if (is_del && (deletes_counted != '1)) begin
        deletes_counted_next = deletes_counted + TOT_W'(1);
      end
      last_file_size_next = item.written_bytes;
    end

    if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: begin
          window_len_next    = cfg_data[CNT_W-1:0];
          ring_position_next = '0;
          wrapped_next       = 1'b0;
          window_count_next  = '0;
        end
        REG_DELETE_THRESHOLD: delete_threshold_next = cfg_data[CNT_W-1:0];
        REG_SIZE_THRESHOLD:   size_threshold_next   = cfg_data[TOT_W-1:0];
        REG_COUNT_SINGLE:     count_single_next     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len       <= '0;
      delete_threshold <= '0;
      size_threshold   <= '0;
      count_single     <= 1'b1;
      ring_position    <= '0;
      wrapped          <= 1'b0;
      window_count     <= '0;
      window_max       <= '0;
      entries_counted  <= '0;
      deletes_counted  <= '0;
      last_file_size   <= '0;
    end else begin
      window_len       <= window_len_next;
      delete_threshold <= delete_threshold_next;
      size_threshold   <= size_threshold_next;
      count_single     <= count_single_next;
      ring_position    <= ring_position_next;
      wrapped          <= wrapped_next;
      window_count     <= window_count_next;
      window_max       <= window_max_next;
      entries_counted  <= entries_counted_next;
      deletes_counted  <= deletes_counted_next;
      last_file_size   <= last_file_size_next;
    end
  end

  // The read address follows the next ring position, so the old bit is ready each cycle.
  swdt_ring u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ring_position),
    .wr_bit  (is_del),
    .rd_addr (ring_position_next),
    .rd_bit  (rd_bit)
  );

  assign cfg.window           = eff_window;
  assign cfg.delete_threshold = delete_threshold;
  assign cfg.size_threshold   = size_threshold;

  assign snap_next.window_count    = window_count_next;
  assign snap_next.window_max      = window_max_next;
  assign snap_next.entries_counted = entries_counted_next;
  assign snap_next.deletes_counted = deletes_counted_next;
  assign snap_next.last_file_size  = last_file_size_next;

endmodule

`default_nettype wire

// ===== sv/swdt_judge.sv =====
// Result pipeline: cross-multiplied ratio products, compaction decision and output register.
`default_nettype none

module swdt_judge
  import swdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  take,
  input  wire snap_t snap_next,
  output logic       free,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  logic              a_valid;
  snap_t             a_snap;
  logic              b_valid;
  logic [CNT_W-1:0]  b_count;
  logic [CNT_W-1:0]  b_max;
  logic              b_gate;
  logic              b_max_hit;
  logic              b_any;
  logic [PROD_W-1:0] b_del_prod;
  logic [PROD_W-1:0] b_thr_prod;

  logic o_free;
  logic b_free;
  logic a_free;
  logic a_move;
  logic b_move;

  assign o_free = !out_valid || out_ready;
  assign b_free = !b_valid || o_free;
  assign a_free = !a_valid || b_free;
  assign a_move = a_valid && b_free;
  assign b_move = b_valid && o_free;
  assign free   = a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= take;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (o_free) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_snap <= snap_next;
    end
    if (a_move) begin
      b_count    <= a_snap.window_count;
      b_max      <= a_snap.window_max;
      b_gate     <= (cfg.delete_threshold != '0) && (cfg.window != '0) &&
                    (a_snap.last_file_size > cfg.size_threshold);
      b_max_hit  <= a_snap.window_max > cfg.delete_threshold;
      b_any      <= a_snap.entries_counted != '0;
      b_del_prod <= PROD_W'(a_snap.deletes_counted) * PROD_W'(cfg.window);
      b_thr_prod <= PROD_W'(cfg.delete_threshold) * PROD_W'(a_snap.entries_counted);
    end
    if (b_move) begin
      out_data.deletes_in_window <= b_count;
      out_data.max_deletes_seen  <= b_max;
      out_data.need_compact      <= b_gate &&
                                    (b_max_hit || (b_any && (b_del_prod > b_thr_prod)));
    end
  end

endmodule

`default_nettype wire

// ===== sv/swdt_checker.sv =====
// Port-level checker for the sliding-window delete tracker, bound to the top level.
`default_nettype none
`include "sliding_window_delete_tracker_defines.svh"

module swdt_checker
  import swdt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `SWDT_ASSERT_NOW(a_max_covers_count, out_valid,
    out_data.max_deletes_seen >= out_data.deletes_in_window,
    "Maximum is below the window count")

  `SWDT_ASSERT_NOW(a_count_in_range, out_valid,
    out_data.deletes_in_window <= MAX_WINDOW_CNT,
    "Window count exceeds the largest window")

  `SWDT_ASSERT_NEXT(a_max_monotonic, out_valid && out_ready,
    !out_valid || (out_data.max_deletes_seen >= $past(out_data.max_deletes_seen)),
    "Maximum fell between consecutive results")

  `SWDT_ASSERT_NEXT(a_out_held, out_valid && !out_ready,
    out_valid && $stable(out_data),
    "Stalled result changed or was dropped")

endmodule

bind sliding_window_delete_tracker swdt_checker u_swdt_checker (.*);

`default_nettype wire

// ===== tb/sliding_window_delete_tracker_test.sv =====
// Self-checking testbench that streams storage entries and register writes into the tracker.
module sliding_window_delete_tracker_test
  import swdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TYPE_W-1:0]    ET_PUT          = 3'd0;
  localparam logic [TYPE_W-1:0]    ET_MERGE        = 3'd3;
  localparam logic [TYPE_W-1:0]    ET_RANGE_DELETE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 4'hF;
  localparam logic [CNT_W-1:0]     CNT_ALL_ONES    = '1;
  localparam logic [TOT_W-1:0]     SIZE_ALL_ONES   = '1;
  localparam int                   DRAIN_CYCLES    = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sliding_window_delete_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow registers and tracker state.
  logic [CNT_W-1:0] cfg_window_len = '0;
  logic [CNT_W-1:0] cfg_delete_threshold = '0;
  logic [TOT_W-1:0] cfg_size_threshold = '0;
  logic             cfg_count_single = 1'b1;

  bit               delete_ring [MAX_WINDOW];
  int unsigned      ring_pos = 0;
  int unsigned      deletes_in_ring = 0;
  int unsigned      peak_deletes = 0;
  logic [TOT_W-1:0] entry_total = '0;
  logic [TOT_W-1:0] delete_total = '0;
  logic [TOT_W-1:0] last_size = '0;

  out_item_t        expected_reports [$];
  logic [TOT_W-1:0] file_bytes = '0;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      entries_sent = 0;
  int unsigned      reports_checked = 0;
  int unsigned      compactions_flagged = 0;
  int unsigned      reg_writes = 0;
  int unsigned      error_count = 0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW_LEN: begin
        cfg_window_len = data[CNT_W-1:0];
        foreach (delete_ring[i]) delete_ring[i] = 1'b0;
        ring_pos = 0;
        deletes_in_ring = 0;
      end
      REG_DELETE_THRESHOLD: cfg_delete_threshold = data[CNT_W-1:0];
      REG_SIZE_THRESHOLD:   cfg_size_threshold = data[TOT_W-1:0];
      REG_COUNT_SINGLE:     cfg_count_single = data[0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t track_entry(in_item_t e);
    out_item_t   r;
    logic        is_del;
    int unsigned w;
    logic [63:0] del_product;
    logic [63:0] thr_product;
    w = (cfg_window_len > MAX_WINDOW) ? MAX_WINDOW : cfg_window_len;
    if (e.key_bytes >= MIN_KEY_BYTES) begin
      is_del = (e.entry_type == ET_DELETE) ||
               (e.entry_type == ET_SINGLE_DELETE && cfg_count_single);
      if (w != 0) begin
        if (ring_pos >= w) ring_pos = 0;
        if (delete_ring[ring_pos] != is_del) begin
          delete_ring[ring_pos] = is_del;
          if (is_del) begin
            deletes_in_ring++;
            if (deletes_in_ring > peak_deletes) peak_deletes = deletes_in_ring;
          end else if (deletes_in_ring > 0) begin
            deletes_in_ring--;
          end
        end
        ring_pos = (ring_pos + 1 >= w) ? 0 : ring_pos + 1;
      end
      if (entry_total != SIZE_ALL_ONES) entry_total++;
      if (is_del && delete_total != SIZE_ALL_ONES) delete_total++;
      last_size = e.written_bytes;
    end
    del_product = 64'(delete_total) * 64'(w);
    thr_product = 64'(cfg_delete_threshold) * 64'(entry_total);
    r.deletes_in_window = CNT_W'(deletes_in_ring);
    r.max_deletes_seen  = CNT_W'(peak_deletes);
    r.need_compact = (cfg_delete_threshold != 0) && (w != 0) &&
                     (last_size > cfg_size_threshold) &&
                     ((peak_deletes > cfg_delete_threshold) ||
                      (entry_total != 0 && del_product > thr_product));
    return r;
  endfunction

  function automatic in_item_t entry(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                                     logic [TOT_W-1:0] size);
    in_item_t e;
    e.entry_type    = kind;
    e.key_bytes     = key;
    e.written_bytes = size;
    return e;
  endfunction

  function automatic logic [TOT_W-1:0] rand40();
    return TOT_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t random_entry(int unsigned del_pct);
    in_item_t e;
    if ($urandom_range(99) < del_pct)
      e.entry_type = $urandom_range(1) ? ET_DELETE : ET_SINGLE_DELETE;
    else
      e.entry_type = TYPE_W'($urandom_range(7));
    e.key_bytes = ($urandom_range(9) == 0) ? KEY_W'($urandom_range(3))
                                           : KEY_W'($urandom_range(65535, 4));
    file_bytes += TOT_W'($urandom_range(4000));
    e.written_bytes = ($urandom_range(19) == 0) ? rand40() : file_bytes;
    return e;
  endfunction

  task automatic send_entry(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_reports = {expected_reports, track_entry(item)};
    entries_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The write channel is left high; callers lower it once their writes are done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic set_config(logic [CNT_W-1:0] win, logic [CNT_W-1:0] thr,
                            logic [TOT_W-1:0] size_thr, logic single);
    wait_idle();
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(win));
    write_reg(REG_DELETE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SIZE_THRESHOLD, CFG_DATA_W'(size_thr));
    write_reg(REG_COUNT_SINGLE, CFG_DATA_W'(single));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_report
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_data.need_compact === 1'b1) compactions_flagged++;
        if (out_data.deletes_in_window !== want.deletes_in_window) begin
          $error("deletes_in_window: expected %0d, got %0d",
                 want.deletes_in_window, out_data.deletes_in_window);
          error_count++;
        end
        if (out_data.max_deletes_seen !== want.max_deletes_seen) begin
          $error("max_deletes_seen: expected %0d, got %0d",
                 want.max_deletes_seen, out_data.max_deletes_seen);
          error_count++;
        end
        if (out_data.need_compact !== want.need_compact) begin
          $error("need_compact: expected %0b, got %0b",
                 want.need_compact, out_data.need_compact);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic test_reset_defaults();
    send_entry(entry(ET_DELETE, MIN_KEY_BYTES, 40'd100));
    send_entry(entry(ET_PUT, MIN_KEY_BYTES, 40'd200));
    set_config('0, 13'd1, '0, 1'b1);
    send_entry(entry(ET_DELETE, 16'd50, 40'd300));
  endtask

  task automatic test_entry_types();
    logic [TOT_W-1:0] size;
    size = 40'd1000;
    set_config(13'd8, 13'd1, '0, 1'b1);
    for (int t = 0; t < 8; t++) begin
      size += 40'd1000;
      send_entry(entry(TYPE_W'(t), MIN_KEY_BYTES, size));
    end
    send_entry(entry(ET_DELETE, 16'd0, size));
    send_entry(entry(ET_DELETE, 16'd3, size));
    send_entry(entry(ET_DELETE, 16'hFFFF, SIZE_ALL_ONES));
    send_entry(entry(ET_PUT, 16'hFFFF, '0));
  endtask

  task automatic test_single_delete_setting();
    wait_idle();
    write_reg(REG_COUNT_SINGLE, '0);
    cfg_valid <= 1'b0;
    send_entry(entry(ET_SINGLE_DELETE, 16'd8, 40'd9000));
    send_entry(entry(ET_SINGLE_DELETE, 16'd8, 40'd9100));
    wait_idle();
    write_reg(REG_COUNT_SINGLE, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    send_entry(entry(ET_SINGLE_DELETE, 16'd8, 40'd9200));
  endtask

  task automatic test_window_rewrite();
    set_config(13'd3, 13'd2, 40'd100, 1'b1);
    send_entry(entry(ET_DELETE, 16'd20, 40'd500));
    send_entry(entry(ET_DELETE, 16'd20, 40'd600));
    send_entry(entry(ET_DELETE, 16'd20, 40'd700));
    send_entry(entry(ET_PUT, 16'd20, 40'd800));
    send_entry(entry(ET_MERGE, 16'd20, 40'd900));
  endtask

  task automatic test_oversized_window();
    set_config(CNT_ALL_ONES, CNT_ALL_ONES, SIZE_ALL_ONES, 1'b0);
    @(posedge clk);
    write_reg(REG_UNUSED, CFG_DATA_W'(rand40()));
    cfg_valid <= 1'b0;
    send_entry(entry(ET_DELETE, 16'd64, 40'd1000));
    wait_idle();
    write_reg(REG_DELETE_THRESHOLD, CFG_DATA_W'(1));
    write_reg(REG_SIZE_THRESHOLD, '0);
    cfg_valid <= 1'b0;
    send_entry(entry(ET_RANGE_DELETE, 16'd64, 40'd5));
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] thr;
    logic [TOT_W-1:0] size_thr;
    int unsigned      del_pct;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(9))
          0: win = 13'd1;
          1: win = 13'd2;
          2: win = CNT_W'(MAX_WINDOW);
          3: win = CNT_W'($urandom_range(8191, MAX_WINDOW + 1));
          4: win = '0;
          default: win = CNT_W'($urandom_range(40, 3));
        endcase
        case ($urandom_range(7))
          0: thr = '0;
          1: thr = CNT_ALL_ONES;
          default: thr = CNT_W'($urandom_range(12, 1));
        endcase
        case ($urandom_range(7))
          0: size_thr = '0;
          1: size_thr = SIZE_ALL_ONES;
          default: size_thr = file_bytes + TOT_W'($urandom_range(60000));
        endcase
        del_pct = $urandom_range(100);
        set_config(win, thr, size_thr, 1'($urandom_range(1)));
        for (int i = 0; i < 36; i++) send_entry(random_entry(del_pct));
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_entry_types();
    test_single_delete_setting();
    test_window_rewrite();
    test_oversized_window();
    test_random_traffic();
    wait_idle();
    $display("Run covered %0d entries and %0d register writes across four idling patterns.",
             entries_sent, reg_writes);
    $display("%0d results were checked, %0d of them asking for compaction.",
             reports_checked, compactions_flagged);
    if (error_count == 0)
      $display("sliding_window_delete_tracker test passed");
    else
      $display("sliding_window_delete_tracker test failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("sliding_window_delete_tracker test failed");
    $finish;
  end

endmodule
